/* rtl/mtkr_pkg.sv */
`timescale 1ns / 1ps

package mtkr_pkg;

  // Slot store geometry and result cap per item
  localparam int unsigned Slots     = 8;
  localparam int unsigned MaxOut    = 8;
  localparam int unsigned SlotIdxW  = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned CntW      = $clog2(MaxOut + 1);

  localparam logic [15:0] TermReset = 16'd200;
  localparam logic [7:0]  DualLo    = 8'hE0;
  localparam logic [7:0]  DualHi    = 8'hE7;

  typedef enum logic [1:0] {
    MODE_KEY   = 2'd0,
    MODE_TICK  = 2'd1,
    MODE_OTHER = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_HELD = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_KEY_DOWN = 3'd1,
    ACT_KEY_UP   = 3'd2,
    ACT_MOD_DOWN = 3'd3,
    ACT_MOD_UP   = 3'd4
  } act_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] key_code;
    logic        is_press;
    logic [7:0]  key_row;
    logic [7:0]  key_col;
  } in_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] report_code;
    logic       pass_through;
    logic       last;
  } out_t;

  typedef struct packed {
    phase_e      phase;
    logic [31:0] stamp;
    logic [15:0] key;
    logic [7:0]  row;
    logic [7:0]  col;
  } slot_t;

  // Write request into the slot store; full=0 updates the phase only
  typedef struct packed {
    logic                en;
    logic                full;
    logic [SlotIdxW-1:0] idx;
    slot_t               entry;
  } slot_wr_t;

  // Flags from the shared compare unit
  typedef struct packed {
    logic match;
    logic idle;
    logic waiting;
    logic held;
    logic expired;
  } cmp_t;

endpackage

/* rtl/mtkr_slot_store.sv */
`timescale 1ns / 1ps

module mtkr_slot_store (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [mtkr_pkg::SlotIdxW-1:0] rd_idx_i,
  output mtkr_pkg::slot_t              rd_entry_o,
  input  mtkr_pkg::slot_wr_t           wr_i
);
  import mtkr_pkg::*;

  slot_t slots_q [Slots];

  // Reset brings every slot to idle with zero position, key and stamp
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Slots; i++) begin
        slots_q[i] <= '0;
      end
    end else if (wr_i.en) begin
      if (wr_i.full) begin
        slots_q[wr_i.idx] <= wr_i.entry;
      end else begin
        slots_q[wr_i.idx].phase <= wr_i.entry.phase;
      end
    end
  end

  assign rd_entry_o = slots_q[rd_idx_i];

endmodule

/* rtl/mtkr_cmp_unit.sv */
`timescale 1ns / 1ps

module mtkr_cmp_unit (
  input  mtkr_pkg::slot_t slot_i,
  input  logic [31:0]     now_i,
  input  logic [15:0]     term_i,
  input  logic [7:0]      row_i,
  input  logic [7:0]      col_i,
  output mtkr_pkg::cmp_t  flags_o
);
  import mtkr_pkg::*;

  logic [31:0] elapsed;

  // Wrapping elapsed time against the tapping term
  assign elapsed          = now_i - slot_i.stamp;
  assign flags_o.expired  = (elapsed >= {16'd0, term_i});
  assign flags_o.match    = (slot_i.row == row_i) && (slot_i.col == col_i);
  assign flags_o.idle     = (slot_i.phase == PH_IDLE);
  assign flags_o.waiting  = (slot_i.phase == PH_WAIT);
  assign flags_o.held     = (slot_i.phase == PH_HELD);

endmodule

/* rtl/mod_tap_key_resolver.sv */
`timescale 1ns / 1ps
// An accepted item is resolved by scanning the slots one per cycle, while the output
// is not stalled, through one compare unit; a new item is taken only once the last is done.
// A tick or other-key item scans every slot; a key event scans, then acts on the picked
// slot, and a tap adds a key-up beat; an early slot match ends the scan sooner. A key
// that is not dual-role passes straight through.
// Reset: all slots idle and zeroed, millisecond count zero, tapping term 200.

module mod_tap_key_resolver (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mtkr_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output mtkr_pkg::out_t out_data_o,
  input  logic           cfg_we_i,
  input  logic [15:0]    cfg_wdata_i
);
  import mtkr_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_ACT  = 5'b00100,
    ST_REL2 = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  in_t                 item_q, item_d;
  logic [SlotIdxW-1:0] idx_q, idx_d;
  logic [SlotIdxW-1:0] pick_q, pick_d;
  logic                pick_vld_q, pick_vld_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [31:0]         now_q, now_d;
  logic [15:0]         term_q;
  out_t                pend_q, pend_d;
  logic                pend_vld_q, pend_vld_d;
  out_t                out_q, out_d;
  logic                out_valid_q;
  logic                out_load;

  logic                out_free;
  logic                step;
  logic                in_acc;
  logic                dual;
  logic                new_emit;
  out_t                new_res;
  logic [SlotIdxW-1:0] rd_idx;
  slot_t               rd_entry;
  slot_wr_t            wr;
  cmp_t                flags;
  logic                idx_last;

  mtkr_slot_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_idx_i   (rd_idx),
    .rd_entry_o (rd_entry),
    .wr_i       (wr)
  );

  mtkr_cmp_unit u_cmp (
    .slot_i  (rd_entry),
    .now_i   (now_q),
    .term_i  (term_q),
    .row_i   (item_q.key_row),
    .col_i   (item_q.key_col),
    .flags_o (flags)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = out_free;
  assign rd_idx     = (state_q == ST_ACT) ? pick_q : idx_q;
  assign idx_last   = (idx_q == SlotIdxW'(Slots - 1));
  assign dual       = (in_data_i.key_code[15:8] >= DualLo) &&
                      (in_data_i.key_code[15:8] <= DualHi);

  // Sequencer: scan slots, act on the picked slot for key events, then close the item
  always_comb begin
    state_d    = state_q;
    item_d     = item_q;
    idx_d      = idx_q;
    pick_d     = pick_q;
    pick_vld_d = pick_vld_q;
    cnt_d      = cnt_q;
    now_d      = now_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    out_d      = out_q;
    out_load   = 1'b0;
    new_emit   = 1'b0;
    new_res    = '0;
    wr         = '0;
    wr.idx     = rd_idx;
    wr.entry   = rd_entry;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          item_d     = in_data_i;
          idx_d      = '0;
          pick_vld_d = 1'b0;
          cnt_d      = '0;
          case (mode_e'(in_data_i.mode))
            MODE_KEY: begin
              if (dual) begin
                state_d = ST_SCAN;
              end else begin
                pend_d       = '0;
                pend_d.action       = ACT_NONE;
                pend_d.pass_through = 1'b1;
                pend_vld_d   = 1'b1;
                state_d      = ST_DONE;
              end
            end
            MODE_TICK: begin
              now_d   = now_q + 32'd1;
              state_d = ST_SCAN;
            end
            MODE_OTHER: state_d = ST_SCAN;
            default:    state_d = ST_DONE;
          endcase
        end
      end

      ST_SCAN: begin
        if (step) begin
          idx_d = idx_q + SlotIdxW'(1);
          if (mode_e'(item_q.mode) == MODE_KEY) begin
            if (flags.match) begin
              pick_d     = idx_q;
              pick_vld_d = 1'b1;
              state_d    = ST_ACT;
            end else begin
              if (flags.idle && !pick_vld_q) begin
                pick_d     = idx_q;
                pick_vld_d = 1'b1;
              end
              if (idx_last) begin
                state_d = (pick_vld_q || flags.idle) ? ST_ACT : ST_DONE;
              end
            end
          end else begin
            // Promote waiting slots to held, up to the per-item cap
            if (flags.waiting && (flags.expired || mode_e'(item_q.mode) == MODE_OTHER) &&
                (cnt_q < CntW'(MaxOut))) begin
              wr.en             = 1'b1;
              wr.entry.phase    = PH_HELD;
              new_emit          = 1'b1;
              new_res.action    = ACT_MOD_DOWN;
              new_res.report_code = rd_entry.key[15:8];
              cnt_d             = cnt_q + CntW'(1);
            end
            if (idx_last) begin
              state_d = ST_DONE;
            end
          end
        end
      end

      ST_ACT: begin
        if (step) begin
          wr.en = 1'b1;
          if (item_q.is_press) begin
            wr.full        = 1'b1;
            wr.entry.phase = PH_WAIT;
            wr.entry.stamp = now_q;
            wr.entry.key   = item_q.key_code;
            wr.entry.row   = item_q.key_row;
            wr.entry.col   = item_q.key_col;
            state_d        = ST_DONE;
          end else begin
            wr.entry.phase = PH_IDLE;
            if (flags.waiting && !flags.expired) begin
              new_emit            = 1'b1;
              new_res.action      = ACT_KEY_DOWN;
              new_res.report_code = item_q.key_code[7:0];
              state_d             = ST_REL2;
            end else begin
              if (flags.held) begin
                new_emit            = 1'b1;
                new_res.action      = ACT_MOD_UP;
                new_res.report_code = item_q.key_code[15:8];
              end
              state_d = ST_DONE;
            end
          end
        end
      end

      ST_REL2: begin
        if (step) begin
          new_emit            = 1'b1;
          new_res.action      = ACT_KEY_UP;
          new_res.report_code = item_q.key_code[7:0];
          state_d             = ST_DONE;
        end
      end

      ST_DONE: begin
        if (step) begin
          // Final beat of the item carries the last flag
          if (pend_vld_q) begin
            out_load   = 1'b1;
            out_d      = pend_q;
            out_d.last = 1'b1;
            pend_vld_d = 1'b0;
          end
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    // A new result pushes the held one out as a non-final beat
    if (new_emit) begin
      if (pend_vld_q) begin
        out_load   = 1'b1;
        out_d      = pend_q;
        out_d.last = 1'b0;
      end
      pend_d     = new_res;
      pend_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      pick_q      <= '0;
      pick_vld_q  <= 1'b0;
      cnt_q       <= '0;
      now_q       <= '0;
      term_q      <= TermReset;
      pend_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      pick_q     <= pick_d;
      pick_vld_q <= pick_vld_d;
      cnt_q      <= cnt_d;
      now_q      <= now_d;
      pend_vld_q <= pend_vld_d;
      if (cfg_we_i) begin
        term_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_state_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_idle_no_pend : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_vld_q)
    else $error("result left pending while idle");

  a_tap_pair : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REL2) |-> (pend_vld_q && pend_q.action == ACT_KEY_DOWN))
    else $error("tap release without pending key press");

  a_pass_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.action == ACT_NONE) |->
      (out_data_o.pass_through && out_data_o.last))
    else $error("pass-through beat malformed");
`endif

endmodule
